FILE: sv/cts_pkg.sv
// shared types, constants and character tables of the token scanner
`timescale 1ns / 1ps
package cts_pkg;

	localparam int KW_COUNT = 6;
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

	// token kinds as they leave the block
	typedef enum logic [2:0] {
		KIND_KEYWORD  = 3'd0,
		KIND_OPERATOR = 3'd1,
		KIND_NUMBER   = 3'd2,
		KIND_IDENT    = 3'd3,
		KIND_TAIL     = 3'd4,
		KIND_ERROR    = 3'd5
	} kind_t;

	// character categories found by the front end
	typedef enum logic [2:0] {
		CC_BLANK  = 3'd0,
		CC_LEAD   = 3'd1,
		CC_SINGLE = 3'd2,
		CC_DIGIT  = 3'd3,
		CC_WORD   = 3'd4,
		CC_BAD    = 3'd5
	} char_cat_t;

	// operators that wait for a following '='
	typedef enum logic [2:0] {
		LEAD_NONE = 3'd0,
		LEAD_EQ   = 3'd1,
		LEAD_BANG = 3'd2,
		LEAD_LT   = 3'd3,
		LEAD_GT   = 3'd4
	} lead_t;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_WORD   = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_OPER   = 4'b1000
	} mode_t;

	// one-byte operator details of the lookahead characters
	localparam logic [4:0] OP_ASSIGN = 5'd8;
	localparam logic [4:0] OP_LESS   = 5'd16;
	localparam logic [4:0] OP_MORE   = 5'd17;

	// classified input beat
	typedef struct packed {
		logic       eot;
		char_cat_t  cat;
		lead_t      lead;
		logic [4:0] op_detail;
		logic [7:0] ch;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  detail;
		logic [15:0] start;
		logic [15:0] length;
		logic [30:0] value;
		logic        last;
	} token_t;

	function automatic logic [2:0] kw_len(input logic [2:0] idx);
		case (idx)
			3'd0: return 3'd3;
			3'd1: return 3'd2;
			3'd2: return 3'd4;
			3'd3: return 3'd3;
			3'd4: return 3'd5;
			3'd5: return 3'd6;
			default: return 3'd0;
		endcase
	endfunction

	// keyword spelling: int if else for while return
	function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (idx)
			3'd0: begin
				case (pos)
					3'd0: c = 8'h69;
					3'd1: c = 8'h6E;
					3'd2: c = 8'h74;
					default: c = 8'h00;
				endcase
			end
			3'd1: begin
				case (pos)
					3'd0: c = 8'h69;
					3'd1: c = 8'h66;
					default: c = 8'h00;
				endcase
			end
			3'd2: begin
				case (pos)
					3'd0: c = 8'h65;
					3'd1: c = 8'h6C;
					3'd2: c = 8'h73;
					3'd3: c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			3'd3: begin
				case (pos)
					3'd0: c = 8'h66;
					3'd1: c = 8'h6F;
					3'd2: c = 8'h72;
					default: c = 8'h00;
				endcase
			end
			3'd4: begin
				case (pos)
					3'd0: c = 8'h77;
					3'd1: c = 8'h68;
					3'd2: c = 8'h69;
					3'd3: c = 8'h6C;
					3'd4: c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			3'd5: begin
				case (pos)
					3'd0: c = 8'h72;
					3'd1: c = 8'h65;
					3'd2: c = 8'h74;
					3'd3: c = 8'h75;
					3'd4: c = 8'h72;
					3'd5: c = 8'h6E;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic kw_hit(input logic [2:0] idx, input logic [2:0] pos,
		input logic [7:0] ch);
		return (pos < kw_len(idx)) && (kw_char(idx, pos) == ch);
	endfunction

	function automatic item_t classify(input logic [7:0] ch);
		item_t it;
		it.eot = 1'b0;
		it.cat = CC_BAD;
		it.lead = LEAD_NONE;
		it.op_detail = 5'd0;
		it.ch = ch;
		case (ch)
			8'h09, 8'h0A, 8'h0D, 8'h20: it.cat = CC_BLANK;
			8'h3D: begin it.cat = CC_LEAD; it.lead = LEAD_EQ;   end // =
			8'h21: begin it.cat = CC_LEAD; it.lead = LEAD_BANG; end // !
			8'h3C: begin it.cat = CC_LEAD; it.lead = LEAD_LT;   end // <
			8'h3E: begin it.cat = CC_LEAD; it.lead = LEAD_GT;   end // >
			8'h2B: begin it.cat = CC_SINGLE; it.op_detail = 5'd4;  end // +
			8'h2D: begin it.cat = CC_SINGLE; it.op_detail = 5'd5;  end // -
			8'h2A: begin it.cat = CC_SINGLE; it.op_detail = 5'd6;  end // *
			8'h2F: begin it.cat = CC_SINGLE; it.op_detail = 5'd7;  end // /
			8'h26: begin it.cat = CC_SINGLE; it.op_detail = 5'd9;  end // &
			8'h2C: begin it.cat = CC_SINGLE; it.op_detail = 5'd10; end // ,
			8'h3B: begin it.cat = CC_SINGLE; it.op_detail = 5'd11; end // ;
			8'h28: begin it.cat = CC_SINGLE; it.op_detail = 5'd12; end // (
			8'h29: begin it.cat = CC_SINGLE; it.op_detail = 5'd13; end // )
			8'h7B: begin it.cat = CC_SINGLE; it.op_detail = 5'd14; end // {
			8'h7D: begin it.cat = CC_SINGLE; it.op_detail = 5'd15; end // }
			default: begin
				if (ch >= 8'h30 && ch <= 8'h39) begin
					it.cat = CC_DIGIT;
				end else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
					|| ch == 8'h5F) begin
					it.cat = CC_WORD;
				end else begin
					it.cat = CC_BAD;
				end
			end
		endcase
		return it;
	endfunction

endpackage

FILE: sv/cts_front.sv
// input side: takes text beats, classifies each byte and queues it
`timescale 1ns / 1ps
module cts_front import cts_pkg::*; (
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // text_byte
	input  logic       s_axis_tlast,  // end_of_text
	output logic       push,
	output item_t      push_item,
	input  logic       queue_full
);

	item_t cls;

	always_comb begin
		cls = classify(s_axis_tdata);
		cls.eot = s_axis_tlast;
	end

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;
	assign push_item     = cls;

endmodule

FILE: sv/cts_fifo.sv
// small register queue between the classifier and the scanner
`timescale 1ns / 1ps
module cts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: sv/cts_back.sv
// scanner proper: token state, token assembly and output register pair
`timescale 1ns / 1ps
module cts_back import cts_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // detail, start, length, value, zero pad
	output logic [2:0]  m_axis_tuser,  // token_kind
	output logic        m_axis_tlast   // last_of_run
);

	localparam int OB = OFFSET_BITS;

	mode_t            mode_q, mode_n;
	lead_t            pend_q, pend_n;
	logic [OB-1:0]    begin_q, begin_n;
	logic [OB-1:0]    pos_q, pos_n;
	logic [KW_COUNT-1:0] cand_q, cand_n;
	logic [30:0]      acc_q, acc_n;
	logic             hold_q, hold_n;

	token_t           out_q, spare_q;
	logic             out_valid_q, spare_valid_q;

	logic [OB-1:0]    len;
	logic             len_small;
	logic [34:0]      acc_ext;
	logic [34:0]      acc_prod;
	logic [30:0]      acc_sat;
	logic [KW_COUNT-1:0] cand_nar, cand_first;
	logic             kw_found;
	logic [2:0]       kw_idx;
	logic             cont;
	logic             hold_mid;
	token_t           tok_a, tok_b, first_tok, second_tok;
	logic             tok_a_v, tok_b_v;
	logic             can_take;
	logic             out_fire;

	always_comb begin
		len       = pos_q - begin_q;
		len_small = (len < OB'(8));
		acc_ext   = {4'b0, acc_q};
		acc_prod  = (acc_ext << 3) + (acc_ext << 1) + {31'b0, head.ch[3:0]};
		acc_sat   = (acc_prod > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_prod[30:0];
		kw_found  = 1'b0;
		kw_idx    = 3'd0;
		for (int i = 0; i < KW_COUNT; i++) begin
			cand_nar[i]   = cand_q[i] && len_small && kw_hit(3'(i), len[2:0], head.ch);
			cand_first[i] = kw_hit(3'(i), 3'd0, head.ch);
		end
		// lowest index wins; spellings differ so at most one matches anyway
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (cand_q[i] && len == OB'(kw_len(3'(i)))) begin
				kw_found = 1'b1;
				kw_idx   = 3'(i);
			end
		end
	end

	// next token state and up to two tokens for the head item
	always_comb begin
		mode_n   = mode_q;
		pend_n   = pend_q;
		begin_n  = begin_q;
		pos_n    = pos_q;
		cand_n   = cand_q;
		acc_n    = acc_q;
		hold_mid = hold_q;
		hold_n   = hold_q;
		cont     = 1'b0;
		tok_a_v  = 1'b0;
		tok_b_v  = 1'b0;
		tok_a    = '{kind: KIND_TAIL, detail: 5'd0, start: 16'd0, length: 16'd0,
			value: 31'd0, last: 1'b0};
		tok_b    = tok_a;

		if (!hold_q) begin
			case (mode_q)
				MODE_WORD: begin
					if (!head.eot && (head.cat == CC_WORD || head.cat == CC_DIGIT)) begin
						cand_n = cand_nar;
						cont   = 1'b1;
					end else begin
						tok_a_v       = 1'b1;
						tok_a.kind    = kw_found ? KIND_KEYWORD : KIND_IDENT;
						tok_a.detail  = kw_found ? {2'b0, kw_idx} : 5'd0;
						tok_a.start   = 16'(begin_q);
						tok_a.length  = 16'(len);
					end
				end
				MODE_NUMBER: begin
					if (!head.eot && head.cat == CC_DIGIT) begin
						acc_n = acc_sat;
						cont  = 1'b1;
					end else begin
						tok_a_v      = 1'b1;
						tok_a.kind   = KIND_NUMBER;
						tok_a.start  = 16'(begin_q);
						tok_a.length = 16'(len);
						tok_a.value  = acc_q;
					end
				end
				MODE_OPER: begin
					tok_a_v     = 1'b1;
					tok_a.start = 16'(begin_q);
					pend_n      = LEAD_NONE;
					if (!head.eot && head.cat == CC_LEAD && head.lead == LEAD_EQ) begin
						// two-byte operator
						tok_a.kind   = KIND_OPERATOR;
						tok_a.detail = 5'(pend_q) - 5'd1;
						tok_a.length = 16'd2;
						cont         = 1'b1;
					end else if (pend_q == LEAD_BANG) begin
						// lone bang
						tok_a.kind   = KIND_ERROR;
						tok_a.length = 16'd1;
						hold_mid     = 1'b1;
					end else begin
						tok_a.kind   = KIND_OPERATOR;
						tok_a.length = 16'd1;
						case (pend_q)
							LEAD_LT: tok_a.detail = OP_LESS;
							LEAD_GT: tok_a.detail = OP_MORE;
							default: tok_a.detail = OP_ASSIGN;
						endcase
					end
				end
				default: ;
			endcase
			if (mode_q != MODE_OPER && cont) begin
				mode_n = mode_q;
			end else begin
				mode_n = MODE_IDLE;
			end
		end

		if (cont) begin
			pos_n = pos_q + 1'b1;
		end else if (head.eot) begin
			tok_b_v      = 1'b1;
			tok_b.kind   = KIND_TAIL;
			tok_b.start  = 16'(pos_q);
			mode_n       = MODE_IDLE;
			pend_n       = LEAD_NONE;
			begin_n      = '0;
			pos_n        = '0;
			cand_n       = '1;
			acc_n        = 31'd0;
			hold_n       = 1'b0;
		end else begin
			hold_n = hold_mid;
			if (!hold_mid) begin
				case (head.cat)
					CC_LEAD: begin
						begin_n = pos_q;
						pend_n  = head.lead;
						mode_n  = MODE_OPER;
					end
					CC_SINGLE: begin
						tok_b_v      = 1'b1;
						tok_b.kind   = KIND_OPERATOR;
						tok_b.detail = head.op_detail;
						tok_b.start  = 16'(pos_q);
						tok_b.length = 16'd1;
					end
					CC_DIGIT: begin
						begin_n = pos_q;
						acc_n   = {27'b0, head.ch[3:0]};
						mode_n  = MODE_NUMBER;
					end
					CC_WORD: begin
						begin_n = pos_q;
						cand_n  = cand_first;
						mode_n  = MODE_WORD;
					end
					CC_BAD: begin
						tok_b_v      = 1'b1;
						tok_b.kind   = KIND_ERROR;
						tok_b.start  = 16'(pos_q);
						tok_b.length = 16'd1;
						hold_n       = 1'b1;
					end
					default: ;
				endcase
			end
			pos_n = pos_q + 1'b1;
		end

		first_tok       = tok_a_v ? tok_a : tok_b;
		first_tok.last  = !(tok_a_v && tok_b_v);
		second_tok      = tok_b;
		second_tok.last = 1'b1;
	end

	assign out_fire = out_valid_q && m_axis_tready;
	// output pair has room for two fresh tokens after this edge
	assign can_take = !out_valid_q || (out_fire && !spare_valid_q);
	assign pop      = head_valid && ((!tok_a_v && !tok_b_v) || can_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			pend_q        <= LEAD_NONE;
			begin_q       <= '0;
			pos_q         <= '0;
			cand_q        <= '1;
			acc_q         <= 31'd0;
			hold_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_n;
				pend_q  <= pend_n;
				begin_q <= begin_n;
				pos_q   <= pos_n;
				cand_q  <= cand_n;
				acc_q   <= acc_n;
				hold_q  <= hold_n;
			end
			if (pop && (tok_a_v || tok_b_v)) begin
				out_valid_q   <= 1'b1;
				spare_valid_q <= tok_a_v && tok_b_v;
			end else if (out_fire) begin
				out_valid_q   <= spare_valid_q;
				spare_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (tok_a_v || tok_b_v)) begin
			out_q   <= first_tok;
			spare_q <= second_tok;
		end else if (out_fire && spare_valid_q) begin
			out_q <= spare_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q.value, out_q.length, out_q.start, out_q.detail};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;

endmodule

FILE: sv/c_subset_token_scanner_unit.sv
// top level of the c subset token scanner
// path: an accepted byte is written into the byte queue, and the token it closes is registered
// into the output register pair when the scanner pops that byte from the queue
// throughput: one text byte per cycle unless stalled; a two-token byte holds output two beats
// the rate is set by the scanner's single token-state update and its two-deep output register
// reset: arst_n clears the scanner state, empties the byte queue and drops any pending tokens
`timescale 1ns / 1ps
module c_subset_token_scanner_unit import cts_pkg::*; #(
	parameter int OFFSET_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// source text, one byte per beat
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  logic        s_axis_tlast,  // end_of_text: beat carries no character
	// tokens
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [4:0] token_detail, [20:5] token_start,
	                                   // [36:21] token_length, [67:37] number_value, zero pad
	output logic [2:0]  m_axis_tuser,  // [2:0] token_kind
	output logic        m_axis_tlast   // last_of_run: last token caused by one input beat
);

	// classified bytes between front end and scanner
	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  queue_empty;
	logic  pop;
	item_t head;

	// front end: handshake and character classification
	cts_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push          (push),
		.push_item     (push_item),
		.queue_full    (queue_full)
	);

	// decoupling queue, lets the input keep flowing while tokens wait
	cts_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_item),
		.full    (queue_full),
		.rd_en   (pop),
		.rd_data (head),
		.empty   (queue_empty)
	);

	// back end: token state machine and output register pair
	cts_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (!queue_empty),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: sv/cts_checker.sv
// port-level checks of the token scanner, bound to the top level
`timescale 1ns / 1ps
module cts_checker import cts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// tail closes a run and has no length or detail
	a_tail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_TAIL
		|-> m_axis_tlast && m_axis_tdata[36:21] == 16'd0 && m_axis_tdata[4:0] == 5'd0)
		else $error("tail beat malformed");

	// error token is one byte long
	a_error_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata[36:21] == 16'd1)
		else $error("error token length not one");

	// only numbers carry a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_NUMBER |-> m_axis_tdata[67:37] == 31'd0)
		else $error("value on non-number token");

	// keyword index stays in the keyword list, others have no detail
	a_detail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_OPERATOR
		|-> (m_axis_tuser == KIND_KEYWORD && m_axis_tdata[4:0] <= 5'd5)
		|| m_axis_tdata[4:0] == 5'd0)
		else $error("bad token detail");

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

endmodule

bind c_subset_token_scanner_unit cts_checker u_cts_checker (.*);

FILE: tb/token_checker.sv
// token checker: predicts the scanner's tokens from the byte beats and compares every token beat
`timescale 1ns / 1ps
module token_checker import cts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // [4:0] token_detail, [20:5] token_start,
	                               // [36:21] token_length, [67:37] number_value, zero pad
	input  logic [2:0]  m_tuser,   // [2:0] token_kind
	input  logic        m_tlast,   // last_of_run
	output int          mismatches,
	output int          tokens_owed,
	output int          tokens_checked,
	output logic [5:0]  kinds_seen
);

	// keyword spellings, right justified, index order is the keyword detail
	localparam logic [47:0] KW_SPELL [6] = '{"int", "if", "else", "for", "while", "return"};
	localparam int KW_SIZE [6] = '{3, 2, 4, 3, 5, 6};
	localparam logic [5:0] ALL_WORDS = 6'h3F;

	// one-byte operators, detail is SINGLE_BASE plus the table index
	localparam logic [7:0] SINGLE_OPS [14] = '{"+", "-", "*", "/", "=", "&", ",", ";",
		"(", ")", "{", "}", "<", ">"};
	localparam int SINGLE_BASE = 4;
	localparam logic [4:0] NO_OP = 5'd31;

	// two-byte operator details
	localparam logic [4:0] OP_EQ_EQ   = 5'd0;
	localparam logic [4:0] OP_NOT_EQ  = 5'd1;
	localparam logic [4:0] OP_LESS_EQ = 5'd2;
	localparam logic [4:0] OP_MORE_EQ = 5'd3;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_LEAD} scan_e;

	scan_e       mode;
	lead_t       lead;
	logic [15:0] tok_begin;
	logic [15:0] text_pos;
	logic [5:0]  cand;
	logic [30:0] acc;
	logic        drop_rest;
	token_t      owed_q [$];

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic token_t make_token(input kind_t kind, input logic [4:0] detail,
		input logic [15:0] start, input logic [15:0] length, input logic [30:0] value);
		token_t t;
		t.kind = kind;
		t.detail = detail;
		t.start = start;
		t.length = length;
		t.value = value;
		t.last = 1'b0;
		return t;
	endfunction

	task automatic restart_text();
		mode = SCAN_IDLE;
		lead = LEAD_NONE;
		tok_begin = '0;
		text_pos = '0;
		cand = ALL_WORDS;
		acc = '0;
		drop_rest = 1'b0;
	endtask

	// drop every keyword that cannot have c at offset p
	task automatic trim_candidates(input logic [7:0] c, input logic [15:0] p);
		logic [47:0] w;
		int k;
		for (k = 0; k < 6; k++) begin
			if (int'(p) >= KW_SIZE[k]) begin
				cand[k] = 1'b0;
			end else begin
				w = KW_SPELL[k] >> (8 * (KW_SIZE[k] - 1 - int'(p)));
				if (w[7:0] != c)
					cand[k] = 1'b0;
			end
		end
	endtask

	task automatic begin_lead(input lead_t l);
		tok_begin = text_pos;
		lead = l;
		mode = SCAN_LEAD;
	endtask

	task automatic scan_beat(input logic [7:0] c, input logic eot);
		token_t          made [$];
		logic            taken;
		logic            found;
		logic [15:0]     len;
		logic [4:0]      op;
		longint unsigned wide;
		int              k;
		taken = 1'b0;
		len = text_pos - tok_begin;
		if (!drop_rest) begin
			case (mode)
				SCAN_WORD: begin
					if (!eot && (is_word_char(c) || is_digit(c))) begin
						trim_candidates(c, len);
						taken = 1'b1;
					end else begin
						found = 1'b0;
						for (k = 0; k < 6; k++) begin
							if (!found && cand[k] && KW_SIZE[k] == int'(len)) begin
								made.push_back(make_token(KIND_KEYWORD, 5'(k), tok_begin, len, '0));
								found = 1'b1;
							end
						end
						if (!found)
							made.push_back(make_token(KIND_IDENT, '0, tok_begin, len, '0));
					end
				end
				SCAN_NUMBER: begin
					if (!eot && is_digit(c)) begin
						wide = longint'(acc) * 10 + longint'(c - "0");
						acc = (wide > longint'(VALUE_MAX)) ? VALUE_MAX : wide[30:0];
						taken = 1'b1;
					end else begin
						made.push_back(make_token(KIND_NUMBER, '0, tok_begin, len, acc));
					end
				end
				SCAN_LEAD: begin
					if (!eot && c == "=") begin
						case (lead)
							LEAD_EQ:   op = OP_EQ_EQ;
							LEAD_BANG: op = OP_NOT_EQ;
							LEAD_LT:   op = OP_LESS_EQ;
							default:   op = OP_MORE_EQ;
						endcase
						made.push_back(make_token(KIND_OPERATOR, op, tok_begin, 16'd2, '0));
						taken = 1'b1;
					end else if (lead == LEAD_BANG) begin
						// a bang without '=' is an error and holds until the end beat
						made.push_back(make_token(KIND_ERROR, '0, tok_begin, 16'd1, '0));
						drop_rest = 1'b1;
					end else begin
						case (lead)
							LEAD_EQ: op = OP_ASSIGN;
							LEAD_LT: op = OP_LESS;
							default: op = OP_MORE;
						endcase
						made.push_back(make_token(KIND_OPERATOR, op, tok_begin, 16'd1, '0));
					end
					lead = LEAD_NONE;
					mode = SCAN_IDLE;
				end
				default: ;
			endcase
			if (!taken)
				mode = SCAN_IDLE;
		end

		if (taken) begin
			text_pos = text_pos + 16'd1;
		end else if (eot) begin
			made.push_back(make_token(KIND_TAIL, '0, text_pos, '0, '0));
			restart_text();
		end else begin
			if (!drop_rest) begin
				case (c)
					8'h09, 8'h0A, 8'h0D, 8'h20: ; // blanks only separate
					"=": begin_lead(LEAD_EQ);
					"!": begin_lead(LEAD_BANG);
					"<": begin_lead(LEAD_LT);
					">": begin_lead(LEAD_GT);
					default: begin
						op = NO_OP;
						for (k = 0; k < 14; k++)
							if (SINGLE_OPS[k] == c)
								op = 5'(SINGLE_BASE + k);
						if (op != NO_OP) begin
							made.push_back(make_token(KIND_OPERATOR, op, text_pos, 16'd1, '0));
						end else if (is_digit(c)) begin
							tok_begin = text_pos;
							acc = 31'(c - "0");
							mode = SCAN_NUMBER;
						end else if (is_word_char(c)) begin
							tok_begin = text_pos;
							cand = ALL_WORDS;
							trim_candidates(c, 16'd0);
							mode = SCAN_WORD;
						end else begin
							made.push_back(make_token(KIND_ERROR, '0, text_pos, 16'd1, '0));
							drop_rest = 1'b1;
						end
					end
				endcase
			end
			text_pos = text_pos + 16'd1;
		end

		if (made.size() > 0)
			made[made.size() - 1].last = 1'b1;
		foreach (made[i])
			owed_q.push_back(made[i]);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_token();
		token_t want;
		if (owed_q.size() == 0) begin
			$error("token beat with nothing predicted: token_kind %0d token_start %0d",
				m_tuser, m_tdata[20:5]);
			mismatches++;
		end else begin
			want = owed_q.pop_front();
			check_field("token_kind", want.kind, m_tuser);
			check_field("token_detail", want.detail, m_tdata[4:0]);
			check_field("token_start", want.start, m_tdata[20:5]);
			check_field("token_length", want.length, m_tdata[36:21]);
			check_field("number_value", want.value, m_tdata[67:37]);
			check_field("last_of_run", want.last, m_tlast);
			tokens_checked++;
			kinds_seen[want.kind] = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_text();
			owed_q.delete();
			mismatches = 0;
			tokens_owed = 0;
			tokens_checked = 0;
			kinds_seen = '0;
		end else begin
			if (m_tvalid && m_tready)
				check_token();
			if (s_tvalid && s_tready)
				scan_beat(s_tdata, s_tlast);
			tokens_owed = owed_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
// testbench top: drives source text into the token scanner and gives the verdict
`timescale 1ns / 1ps
module tb;

	// longest quiet stretch of a correct run is a receiver stall back to back
	// with a sender gap plus the path through the byte queue and output pair,
	// so this is many times what a healthy block ever needs
	localparam int QUIET_LIMIT = 400;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          mismatches;
	int          tokens_owed;
	int          tokens_checked;
	logic [5:0]  kinds_seen;

	bit          calm = 1'b0;     // last part of the run: no idling on either side
	int          beats_sent = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	string kw_names [6] = '{"int", "if", "else", "for", "while", "return"};
	string op_spell [18] = '{"==", "!=", "<=", ">=", "+", "-", "*", "/", "=", "&", ",", ";",
		"(", ")", "{", "}", "<", ">"};

	c_subset_token_scanner_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	token_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.s_tlast        (s_axis_tlast),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tuser        (m_axis_tuser),
		.m_tlast        (m_axis_tlast),
		.mismatches     (mismatches),
		.tokens_owed    (tokens_owed),
		.tokens_checked (tokens_checked),
		.kinds_seen     (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// token receiver: random stalls, always ready once calm
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(1, 14);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog: too many cycles without a beat on either side ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d tokens still owed",
					quiet_cycles, tokens_owed);
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one byte beat; an occasional gap with valid low comes before it,
	// then valid is held until the scanner takes the beat
	task automatic send_beat(input logic [7:0] b, input logic eot);
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// end of text beat; the data byte is meaningless and so random
	task automatic end_text();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return 8'h09;  // tab
			1: return 8'h0A;  // line feed
			2: return 8'h0D;  // carriage return
			default: return 8'h20;
		endcase
	endfunction

	// letter, underscore and, past the first byte of a word, digit
	function automatic logic [7:0] word_char(input bit allow_digit);
		int r;
		r = $urandom_range(0, allow_digit ? 62 : 52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + (r - 26));
		else if (r == 52)
			return "_";
		else
			return 8'("0" + (r - 53));
	endfunction

	// one token-shaped chunk; mostly well formed, a little noise that
	// triggers the error hold for the rest of the text
	task automatic send_random_token();
		int pick;
		int r;
		int i;
		string kw;
		pick = $urandom_range(0, 99);
		kw = kw_names[$urandom_range(0, 5)];
		if (pick < 20) begin
			send_text(kw);
		end else if (pick < 25) begin
			// keyword prefix, so candidates survive but length is short
			for (i = 0; i < kw.len() - 1; i++)
				send_beat(kw[i], 1'b0);
		end else if (pick < 30) begin
			// keyword with one more word byte, becomes an identifier
			send_text(kw);
			send_beat(word_char(1'b1), 1'b0);
		end else if (pick < 42) begin
			send_beat(word_char(1'b0), 1'b0);
			repeat ($urandom_range(0, 7)) send_beat(word_char(1'b1), 1'b0);
		end else if (pick < 62) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_text("2147483647");  // largest value, no saturation
			else if (r == 1)
				send_text("2147483648");  // one past, saturates
			else if (r < 4)
				repeat ($urandom_range(10, 14))
					send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
			else
				repeat ($urandom_range(1, 4))
					send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
		end else if (pick < 94) begin
			send_text(op_spell[$urandom_range(0, 17)]);
		end else if (pick < 97) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			// bang followed by anything, usually a lone bang error
			send_beat("!", 1'b0);
			send_beat(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// a whole text: up to 14 chunks, blanks between most of them, then the end beat
	task automatic send_random_text();
		repeat ($urandom_range(0, 14)) begin
			send_random_token();
			if ($urandom_range(0, 9) < 7)
				repeat ($urandom_range(1, 3)) send_beat(pick_blank(), 1'b0);
		end
		end_text();
	endtask

	initial begin
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty text with an all-ones data byte
		send_beat(8'hFF, 1'b1);
		// every two-byte operator, then '<' closed by '>' and '>' closed by the end beat
		send_text("<=>=!===<>");
		send_beat(8'h00, 1'b1);
		// digit run ended by a letter
		send_text("12ab");
		end_text();
		// lone bang, the byte after it is dropped
		send_text("!x");
		end_text();
		// lone bang closed by the end beat itself
		send_beat("!", 1'b0);
		end_text();
		// invalid bytes at both ends of the byte range
		send_beat(8'h00, 1'b0);
		end_text();
		send_beat(8'hFF, 1'b0);
		end_text();

		// random texts with idling on both sides
		target = beats_sent + 1120;
		while (beats_sent < target)
			send_random_text();

		// closing stretch at full rate on both sides
		calm = 1'b1;
		target = beats_sent + 200;
		while (beats_sent < target)
			send_random_text();
		s_axis_tvalid <= 1'b0;

		// drain: let the last beat be predicted, then wait for every token
		@(posedge clk);
		while (tokens_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d text beats and %0d compared tokens", beats_sent, tokens_checked);
		$display("token kinds seen, error down to keyword: %b", kinds_seen);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
